/* hdl/babenc_pkg.sv */
// Package for the binary arithmetic bin encoder.
// Holds the mode codes, the result type and the LPS range and transition tables.
// No dependencies.
`timescale 1ns / 1ps

package babenc_pkg;

    // Input field widths
    localparam int CTX_W   = 10;
    localparam int STATE_W = 7;

    // Coder constants
    localparam logic [8:0]  RANGE_INIT = 9'h1FE;
    localparam logic [10:0] LOW_HALF   = 11'h100;
    localparam logic [10:0] LOW_ONE    = 11'h200;
    localparam logic [10:0] LOW_TWO    = 11'h400;

    typedef enum logic [1:0] {
        MODE_REGULAR   = 2'd0,
        MODE_BYPASS    = 2'd1,
        MODE_TERMINATE = 2'd2,
        MODE_LOAD      = 2'd3
    } mode_t;

    typedef struct packed {
        logic        lead_present;
        logic        lead_bit;
        logic [15:0] follow_count;
        logic        byte_flush;
        logic        overflow;
    } res_t;

    // LPS range, indexed by probability state and range quarter
    localparam logic [7:0] RANGE_LPS_TAB [64][4] = '{
        '{128,176,208,240}, '{128,167,197,227}, '{128,158,187,216}, '{123,150,178,205},
        '{116,142,169,195}, '{111,135,160,185}, '{105,128,152,175}, '{100,122,144,166},
        '{95,116,137,158},  '{90,110,130,150},  '{85,104,123,142},  '{81,99,117,135},
        '{77,94,111,128},   '{73,89,105,122},   '{69,85,100,116},   '{66,80,95,110},
        '{62,76,90,104},    '{59,72,86,99},     '{56,69,81,94},     '{53,65,77,89},
        '{51,62,73,85},     '{48,59,69,80},     '{46,56,66,76},     '{43,53,63,72},
        '{41,50,59,69},     '{39,48,56,65},     '{37,45,54,62},     '{35,43,51,59},
        '{33,41,48,56},     '{32,39,46,53},     '{30,37,43,50},     '{29,35,41,48},
        '{27,33,39,45},     '{26,31,37,43},     '{24,30,35,41},     '{23,28,33,39},
        '{22,27,32,37},     '{21,26,30,35},     '{20,24,29,33},     '{19,23,27,31},
        '{18,22,26,30},     '{17,21,25,28},     '{16,20,23,27},     '{15,19,22,25},
        '{14,18,21,24},     '{14,17,20,23},     '{13,16,19,22},     '{12,15,18,21},
        '{12,14,17,20},     '{11,14,16,19},     '{11,13,15,18},     '{10,12,15,17},
        '{10,12,14,16},     '{9,11,13,15},      '{9,11,12,14},      '{8,10,12,14},
        '{8,9,11,13},       '{7,9,11,12},       '{7,9,10,12},       '{7,8,10,11},
        '{6,8,9,11},        '{6,7,9,10},        '{6,7,8,9},         '{2,2,2,2}
    };

    // Next probability state after an LPS
    localparam logic [5:0] LPS_NEXT [64] = '{
        0,0,1,2,2,4,4,5,6,7,8,9,9,11,11,12,
        13,13,15,15,16,16,18,18,19,19,21,21,22,22,23,24,
        24,25,26,26,27,27,28,29,29,30,30,30,31,32,32,33,
        33,33,34,34,35,35,35,36,36,36,37,37,37,38,38,63
    };

endpackage

/* hdl/binary_arithmetic_bin_encoder.sv */
// Binary arithmetic bin encoder: one shared renormalization step under a sequencer.
// Regular and terminate items renormalize one shift at a time; a terminate with bin 1
// then emits the resolved bit and two stop bits; output stalls can hold any but a load.
// Throughput: loads every cycle; no overlap, a new item waits until the last is done.
// Reset (rst_n low, async) clears the coder, then a pass zeroes every entry of the
// context RAM; no item is accepted until it finishes. Depends on babenc_pkg, babenc_ram.
`timescale 1ns / 1ps

module binary_arithmetic_bin_encoder #(
    parameter int NUM_CONTEXTS = 1024,
    parameter int PENDING_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // bin_value[0], ctx_index[10:1], init_state[17:11]
    input  logic [1:0]  s_tuser,  // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // lead_present[0], lead_bit[1], follow_count[17:2],
                                  // byte_flush[18], overflow[19]
    output logic        m_tlast   // last
);

    import babenc_pkg::*;

    localparam int AW = $clog2(NUM_CONTEXTS);
    localparam logic [AW-1:0] CLR_LAST = AW'(NUM_CONTEXTS - 1);
    localparam logic [CTX_W:0] NUM_CTX_L = (CTX_W + 1)'(NUM_CONTEXTS);
    localparam logic [PENDING_BITS-1:0] PEND_MAX = '1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CTX,
        ST_BYP,
        ST_TERM,
        ST_RENORM,
        ST_PUTB,
        ST_STOP1,
        ST_STOP2,
        ST_FLUSH
    } state_t;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           clr_addr_reg, clr_addr_next;
    mode_t                   mode_reg, mode_next;
    logic                    bin_reg, bin_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic                    valid_reg, valid_next;
    logic [10:0]             low_reg, low_next;
    logic [8:0]              range_reg, range_next;
    logic [PENDING_BITS-1:0] pend_reg, pend_next;
    logic                    first_reg, first_next;
    logic                    lost_reg, lost_next;
    logic                    held_valid_reg, held_valid_next;
    res_t                    held_reg, held_next;
    logic                    out_valid_reg, out_valid_next;
    res_t                    out_reg, out_next;
    logic                    out_last_reg, out_last_next;

    // Input fields
    logic                s_bin;
    logic [CTX_W-1:0]    s_ctx;
    logic [STATE_W-1:0]  s_init;
    mode_t               s_mode;
    logic                s_valid_ctx;
    logic                accept;

    // Context RAM port
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [STATE_W-1:0]  ram_wdata;
    logic [STATE_W-1:0]  ram_rdata;

    // Shared step signals
    logic                emit_req;
    res_t                emit_res;
    logic                out_free;
    logic                can_push;
    logic [31:0]         pend_ext;
    logic [6:0]          ctx;
    logic [5:0]          ps;
    logic                mps;
    logic [7:0]          rlps;
    logic [8:0]          range_mps;
    logic [10:0]         byp_sum;
    logic [8:0]          range_m2;

    assign s_bin   = s_tdata[0];
    assign s_ctx   = s_tdata[10:1];
    assign s_init  = s_tdata[17:11];
    assign s_mode  = mode_t'(s_tuser);
    assign s_valid_ctx = {1'b0, s_ctx} < NUM_CTX_L;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign out_free = !out_valid_reg || m_tready;
    assign can_push = !held_valid_reg || out_free;
    assign pend_ext = 32'(pend_reg);

    // Context decode and LPS range lookup
    assign ctx       = valid_reg ? ram_rdata : '0;
    assign ps        = ctx[6:1];
    assign mps       = ctx[0];
    assign rlps      = RANGE_LPS_TAB[ps][range_reg[7:6]];
    assign range_mps = range_reg - {1'b0, rlps};
    assign byp_sum   = {low_reg[9:0], 1'b0} + (bin_reg ? {2'b00, range_reg} : 11'd0);
    assign range_m2  = range_reg - 9'd2;

    babenc_ram #(
        .WIDTH (STATE_W),
        .DEPTH (NUM_CONTEXTS)
    ) u_ctx_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (s_ctx[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Sequencer and shared coding step
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        mode_next       = mode_reg;
        bin_next        = bin_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        low_next        = low_reg;
        range_next      = range_reg;
        pend_next       = pend_reg;
        first_next      = first_reg;
        lost_next       = lost_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = '0;
        emit_req        = 1'b0;
        emit_res        = '{lead_present: !first_reg, lead_bit: 1'b0,
                            follow_count: pend_ext[15:0], byte_flush: 1'b0,
                            overflow: lost_reg};

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = s_mode;
                    bin_next   = s_bin;
                    idx_next   = s_ctx[AW-1:0];
                    valid_next = s_valid_ctx;
                    unique case (s_mode)
                        MODE_REGULAR:   state_next = ST_CTX;
                        MODE_BYPASS:    state_next = ST_BYP;
                        MODE_TERMINATE: state_next = ST_TERM;
                        MODE_LOAD:
                        begin
                            ram_we    = s_valid_ctx;
                            ram_waddr = s_ctx[AW-1:0];
                            ram_wdata = s_init;
                        end
                        default:        state_next = ST_IDLE;
                    endcase
                end
            end

            ST_CTX:
            begin
                ram_we = valid_reg;
                if (bin_reg == mps)
                begin
                    range_next = range_mps;
                    ram_wdata  = {(ps < 6'd62) ? ps + 6'd1 : ps, mps};
                end
                else
                begin
                    low_next   = low_reg + {2'b00, range_mps};
                    range_next = {1'b0, rlps};
                    ram_wdata  = {LPS_NEXT[ps], mps ^ (ps == 6'd0)};
                end
                state_next = ST_RENORM;
            end

            ST_BYP:
            begin
                priority if (byp_sum[10])
                begin
                    emit_req          = 1'b1;
                    emit_res.lead_bit = 1'b1;
                    if (can_push)
                    begin
                        low_next   = byp_sum - LOW_TWO;
                        state_next = ST_FLUSH;
                    end
                end
                else if (byp_sum < LOW_ONE)
                begin
                    emit_req = 1'b1;
                    if (can_push)
                    begin
                        low_next   = byp_sum;
                        state_next = ST_FLUSH;
                    end
                end
                else
                begin
                    low_next   = byp_sum - LOW_ONE;
                    state_next = ST_FLUSH;
                    if (pend_reg == PEND_MAX)
                    begin
                        lost_next = 1'b1;
                    end
                    else
                    begin
                        pend_next = pend_reg + 1'b1;
                    end
                end
            end

            ST_TERM:
            begin
                range_next = bin_reg ? 9'd2 : range_m2;
                if (bin_reg)
                begin
                    low_next = low_reg + {2'b00, range_m2};
                end
                state_next = ST_RENORM;
            end

            ST_RENORM:
            begin
                priority if (range_reg[8] || range_reg == 9'd0)
                begin
                    state_next = (mode_reg == MODE_TERMINATE && bin_reg) ? ST_PUTB : ST_FLUSH;
                end
                else if (low_reg < LOW_HALF)
                begin
                    emit_req = 1'b1;
                    if (can_push)
                    begin
                        range_next = {range_reg[7:0], 1'b0};
                        low_next   = {low_reg[9:0], 1'b0};
                    end
                end
                else if (low_reg < LOW_ONE)
                begin
                    range_next = {range_reg[7:0], 1'b0};
                    low_next   = {low_reg[9:0] - LOW_HALF[9:0], 1'b0};
                    if (pend_reg == PEND_MAX)
                    begin
                        lost_next = 1'b1;
                    end
                    else
                    begin
                        pend_next = pend_reg + 1'b1;
                    end
                end
                else
                begin
                    emit_req          = 1'b1;
                    emit_res.lead_bit = 1'b1;
                    if (can_push)
                    begin
                        range_next = {range_reg[7:0], 1'b0};
                        low_next   = {low_reg[9:0] - LOW_ONE[9:0], 1'b0};
                    end
                end
            end

            ST_PUTB:
            begin
                emit_req          = 1'b1;
                emit_res.lead_bit = low_reg[9];
                if (can_push)
                begin
                    state_next = ST_STOP1;
                end
            end

            ST_STOP1:
            begin
                emit_req = 1'b1;
                emit_res = '{lead_present: 1'b1, lead_bit: low_reg[8],
                             follow_count: 16'd0, byte_flush: 1'b0, overflow: 1'b0};
                if (can_push)
                begin
                    state_next = ST_STOP2;
                end
            end

            ST_STOP2:
            begin
                emit_req = 1'b1;
                emit_res = '{lead_present: 1'b1, lead_bit: 1'b1,
                             follow_count: 16'd0, byte_flush: 1'b1, overflow: 1'b0};
                if (can_push)
                begin
                    state_next = ST_FLUSH;
                end
            end

            ST_FLUSH:
            begin
                // Release the held item as the last of this input
                if (!held_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = held_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Push a new item: the held one moves out, the new one is held
        if (emit_req && can_push)
        begin
            if (state_reg == ST_PUTB || state_reg == ST_RENORM || state_reg == ST_BYP)
            begin
                first_next = 1'b0;
                pend_next  = '0;
                lost_next  = 1'b0;
            end
            if (held_valid_reg)
            begin
                out_next       = held_reg;
                out_last_next  = 1'b0;
                out_valid_next = 1'b1;
            end
            held_next       = emit_res;
            held_valid_next = 1'b1;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            mode_reg       <= MODE_REGULAR;
            bin_reg        <= 1'b0;
            idx_reg        <= '0;
            valid_reg      <= 1'b0;
            low_reg        <= '0;
            range_reg      <= RANGE_INIT;
            pend_reg       <= '0;
            first_reg      <= 1'b1;
            lost_reg       <= 1'b0;
            held_valid_reg <= 1'b0;
            held_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            mode_reg       <= mode_next;
            bin_reg        <= bin_next;
            idx_reg        <= idx_next;
            valid_reg      <= valid_next;
            low_reg        <= low_next;
            range_reg      <= range_next;
            pend_reg       <= pend_next;
            first_reg      <= first_next;
            lost_reg       <= lost_next;
            held_valid_reg <= held_valid_next;
            held_reg       <= held_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'd0, out_reg.overflow, out_reg.byte_flush, out_reg.follow_count,
                       out_reg.lead_bit, out_reg.lead_present};

endmodule

/* hdl/babenc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module babenc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* test/bin_encoder_checker.sv */
// Checker for the binary arithmetic bin encoder: watches both streams, predicts
// the bit groups that each accepted bin causes and compares them in order.
// Depends on babenc_pkg for the mode codes and the result layout.
`timescale 1ns / 1ps

module bin_encoder_checker
    import babenc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,  // bin_value[0], ctx_index[10:1], init_state[17:11]
    input  logic [1:0]  s_tuser,  // mode[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,  // lead_present[0], lead_bit[1], follow_count[17:2],
                                  // byte_flush[18], overflow[19]
    input  logic        m_tlast,
    output int          fail_count,
    output int          groups_waiting
);

    localparam int          FOLLOW_BITS = 16;
    localparam int unsigned FOLLOW_MAX  = (1 << FOLLOW_BITS) - 1;
    localparam int          MAX_GROUPS  = 10;

    // LPS subrange per probability state and range quarter
    localparam bit [7:0] RLPS_TAB [64][4] = '{
        '{128,176,208,240}, '{128,167,197,227}, '{128,158,187,216}, '{123,150,178,205},
        '{116,142,169,195}, '{111,135,160,185}, '{105,128,152,175}, '{100,122,144,166},
        '{95,116,137,158},  '{90,110,130,150},  '{85,104,123,142},  '{81,99,117,135},
        '{77,94,111,128},   '{73,89,105,122},   '{69,85,100,116},   '{66,80,95,110},
        '{62,76,90,104},    '{59,72,86,99},     '{56,69,81,94},     '{53,65,77,89},
        '{51,62,73,85},     '{48,59,69,80},     '{46,56,66,76},     '{43,53,63,72},
        '{41,50,59,69},     '{39,48,56,65},     '{37,45,54,62},     '{35,43,51,59},
        '{33,41,48,56},     '{32,39,46,53},     '{30,37,43,50},     '{29,35,41,48},
        '{27,33,39,45},     '{26,31,37,43},     '{24,30,35,41},     '{23,28,33,39},
        '{22,27,32,37},     '{21,26,30,35},     '{20,24,29,33},     '{19,23,27,31},
        '{18,22,26,30},     '{17,21,25,28},     '{16,20,23,27},     '{15,19,22,25},
        '{14,18,21,24},     '{14,17,20,23},     '{13,16,19,22},     '{12,15,18,21},
        '{12,14,17,20},     '{11,14,16,19},     '{11,13,15,18},     '{10,12,15,17},
        '{10,12,14,16},     '{9,11,13,15},      '{9,11,12,14},      '{8,10,12,14},
        '{8,9,11,13},       '{7,9,11,12},       '{7,9,10,12},       '{7,8,10,11},
        '{6,8,9,11},        '{6,7,9,10},        '{6,7,8,9},         '{2,2,2,2}
    };

    // State reached after coding an LPS
    localparam bit [5:0] NEXT_ON_LPS [64] = '{
        0,0,1,2,2,4,4,5,6,7,8,9,9,11,11,12,
        13,13,15,15,16,16,18,18,19,19,21,21,22,22,23,24,
        24,25,26,26,27,27,28,29,29,30,30,30,31,32,32,33,
        33,33,34,34,35,35,35,36,36,36,37,37,37,38,38,63
    };

    typedef struct packed {
        res_t grp;
        logic last;
    } bit_group_t;

    bit_group_t  bit_group_q [$];

    // Shadow coder state
    logic [6:0]  ctx_model [1024];
    logic [10:0] coder_low;
    logic [8:0]  coder_range;
    int unsigned follow_run;
    bit          first_lead;
    bit          follow_lost;
    int          step_groups;

    function automatic void push_group(logic present, logic b, logic [15:0] follow,
                                       logic flush, logic ovf);
        bit_group_t g;
        if (step_groups >= MAX_GROUPS)
            return;
        g.grp.lead_present = present;
        g.grp.lead_bit     = b;
        g.grp.follow_count = follow;
        g.grp.byte_flush   = flush;
        g.grp.overflow     = ovf;
        g.last             = 1'b0;
        bit_group_q.push_back(g);
        step_groups++;
    endfunction

    // Resolve a leading bit and flush the run of follow bits behind it
    function automatic void resolve_lead(logic b);
        push_group(!first_lead, b, follow_run[15:0], 1'b0, follow_lost);
        first_lead  = 1'b0;
        follow_run  = 0;
        follow_lost = 1'b0;
    endfunction

    function automatic void add_follow();
        if (follow_run >= FOLLOW_MAX)
        begin
            follow_run  = FOLLOW_MAX;
            follow_lost = 1'b1;
        end
        else
            follow_run++;
    endfunction

    function automatic void renormalize();
        while (coder_range < 9'h100 && coder_range != 9'h000)
        begin
            if (coder_low < 11'h100)
                resolve_lead(1'b0);
            else if (coder_low < 11'h200)
            begin
                add_follow();
                coder_low = coder_low - 11'h100;
            end
            else
            begin
                resolve_lead(1'b1);
                coder_low = coder_low - 11'h200;
            end
            coder_range = {coder_range[7:0], 1'b0};
            coder_low   = {coder_low[9:0], 1'b0};
        end
    endfunction

    // Code one bin or load one context, queueing the bit groups it causes
    function automatic void encode_bin(mode_t mode, logic b, logic [9:0] idx,
                                       logic [6:0] init);
        logic [5:0] ps;
        logic       mps;
        logic [7:0] rlps;
        int         queued_before;
        bit_group_t tail;
        queued_before = bit_group_q.size();
        step_groups   = 0;
        case (mode)
            MODE_LOAD:
                ctx_model[idx] = init;
            MODE_REGULAR:
            begin
                ps   = ctx_model[idx][6:1];
                mps  = ctx_model[idx][0];
                rlps = RLPS_TAB[ps][coder_range[7:6]];
                if (b == mps)
                begin
                    coder_range = coder_range - rlps;
                    if (ps < 6'd62)
                        ps = ps + 6'd1;
                end
                else
                begin
                    coder_low   = coder_low + (coder_range - rlps);
                    coder_range = rlps;
                    if (ps == 6'd0)
                        mps = !mps;
                    ps = NEXT_ON_LPS[ps];
                end
                ctx_model[idx] = {ps, mps};
                renormalize();
            end
            MODE_BYPASS:
            begin
                coder_low = {coder_low[9:0], 1'b0};
                if (b)
                    coder_low = coder_low + coder_range;
                if (coder_low >= 11'h400)
                begin
                    resolve_lead(1'b1);
                    coder_low = coder_low - 11'h400;
                end
                else if (coder_low < 11'h200)
                    resolve_lead(1'b0);
                else
                begin
                    add_follow();
                    coder_low = coder_low - 11'h200;
                end
            end
            MODE_TERMINATE:
            begin
                coder_range = coder_range - 9'd2;
                if (!b)
                    renormalize();
                else
                begin
                    coder_low   = coder_low + coder_range;
                    coder_range = 9'd2;
                    renormalize();
                    // flush: resolved bit, then the two stop bits
                    resolve_lead(coder_low[9]);
                    push_group(1'b1, coder_low[8], 16'd0, 1'b0, 1'b0);
                    push_group(1'b1, 1'b1, 16'd0, 1'b1, 1'b0);
                end
            end
        endcase
        if (bit_group_q.size() > queued_before)
        begin
            tail      = bit_group_q.pop_back();
            tail.last = 1'b1;
            bit_group_q.push_back(tail);
        end
    endfunction

    function automatic void log_miss(string why, bit_group_t want, res_t got, logic got_last);
        if (fail_count < 10)
            $display("%0t %s: expected present=%0b bit=%0b follow=%0d flush=%0b ovf=%0b last=%0b, got present=%0b bit=%0b follow=%0d flush=%0b ovf=%0b last=%0b",
                     $realtime, why, want.grp.lead_present, want.grp.lead_bit,
                     want.grp.follow_count, want.grp.byte_flush, want.grp.overflow, want.last,
                     got.lead_present, got.lead_bit, got.follow_count, got.byte_flush,
                     got.overflow, got_last);
        fail_count++;
    endfunction

    // Compare accepted results, then predict for the accepted bin
    always @(posedge clk or negedge rst_n)
    begin
        bit_group_t want;
        res_t       got;
        if (!rst_n)
        begin
            for (int i = 0; i < 1024; i++)
                ctx_model[i] = 7'd0;
            coder_low      = 11'd0;
            coder_range    = 9'h1FE;
            follow_run     = 0;
            first_lead     = 1'b1;
            follow_lost    = 1'b0;
            bit_group_q.delete();
            fail_count     = 0;
            groups_waiting <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.lead_present = m_tdata[0];
                got.lead_bit     = m_tdata[1];
                got.follow_count = m_tdata[17:2];
                got.byte_flush   = m_tdata[18];
                got.overflow     = m_tdata[19];
                if (bit_group_q.size() == 0)
                    log_miss("unexpected result", '0, got, m_tlast);
                else
                begin
                    want = bit_group_q.pop_front();
                    if (want.grp.lead_present !== got.lead_present
                        || want.grp.lead_bit !== got.lead_bit
                        || want.grp.follow_count !== got.follow_count
                        || want.grp.byte_flush !== got.byte_flush
                        || want.grp.overflow !== got.overflow
                        || want.last !== m_tlast)
                        log_miss("mismatch", want, got, m_tlast);
                end
            end
            if (s_tvalid && s_tready)
                encode_bin(mode_t'(s_tuser), s_tdata[0], s_tdata[10:1], s_tdata[17:11]);
            groups_waiting <= bit_group_q.size();
        end
    end

endmodule

/* test/binary_arithmetic_bin_encoder_tb.sv */
// Testbench top for the binary arithmetic bin encoder: clock, reset, bin stimulus
// and output back-pressure; the checker beside the block gives the failure count.
// Depends on babenc_pkg, binary_arithmetic_bin_encoder and bin_encoder_checker.
`timescale 1ns / 1ps

module binary_arithmetic_bin_encoder_tb;

    import babenc_pkg::*;

    localparam int RANDOM_BINS     = 400;
    localparam int CALM_FROM       = 350;
    localparam int FOLLOW_RUN_BINS = 40;
    localparam int HOLD_CYCLES     = 400;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          groups_waiting;

    bit          idle_on;
    bit          hold_request;
    bit          pressure_done;
    int          bins_sent;
    logic [9:0]  hot_ctx [4];
    logic        hot_mps [4];

    binary_arithmetic_bin_encoder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    bin_encoder_checker encoder_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .fail_count     (fail_count),
        .groups_waiting (groups_waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #5000000;
        $display("status: fail");
        $finish;
    end

    // Output side: random back-pressure bursts, plus one long hold on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offer one bin and hold it until accepted, with an optional gap before it
    task automatic offer(mode_t mode, logic b, logic [9:0] ctx, logic [6:0] init);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 24'($urandom);
            s_tuser  <= 2'($urandom_range(0, 3));
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {6'd0, init, ctx, b};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bins_sent++;
    endtask

    // Load a few contexts, then code mostly regular bins on them
    task automatic run_slice();
        int         n;
        int         pick;
        logic [6:0] st;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++)
        begin
            hot_ctx[k] = 10'($urandom_range(0, 1023));
            st         = 7'($urandom_range(0, 127));
            hot_mps[k] = st[0];
            offer(MODE_LOAD, 1'($urandom_range(0, 1)), hot_ctx[k], st);
        end
        repeat ($urandom_range(3, 12))
        begin
            pick = $urandom_range(0, n - 1);
            if ($urandom_range(0, 4) == 0)
                offer(MODE_BYPASS, 1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                      7'($urandom_range(0, 127)));
            else
                offer(MODE_REGULAR,
                      ($urandom_range(0, 4) == 0) ? !hot_mps[pick] : hot_mps[pick],
                      hot_ctx[pick], 7'($urandom_range(0, 127)));
        end
        if ($urandom_range(0, 3) == 0)
            offer(MODE_TERMINATE, $urandom_range(0, 4) == 0, 10'($urandom_range(0, 1023)),
                  7'($urandom_range(0, 127)));
    endtask

    initial
    begin
        int settle;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = MODE_REGULAR;
        idle_on       = 1'b0;
        hold_request  = 1'b0;
        pressure_done = 1'b0;
        bins_sent     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bypass ones from reset settle low where every bin adds a follow bit,
        // so a long follow run builds up; a bypass zero then resolves it
        repeat (FOLLOW_RUN_BINS)
            offer(MODE_BYPASS, 1'b1, 10'($urandom_range(0, 1023)),
                  7'($urandom_range(0, 127)));
        offer(MODE_BYPASS, 1'b0, 10'd0, 7'd0);

        // Directed: state extremes, MPS flip at state zero, top states, stop bits
        idle_on = 1'b1;
        offer(MODE_LOAD,      1'b1, 10'd1023, 7'd127);
        offer(MODE_REGULAR,   1'b1, 10'd1023, 7'd0);
        offer(MODE_REGULAR,   1'b0, 10'd1023, 7'd127);
        offer(MODE_LOAD,      1'b0, 10'd0,    7'd0);
        offer(MODE_REGULAR,   1'b1, 10'd0,    7'd0);
        offer(MODE_REGULAR,   1'b1, 10'd0,    7'd0);
        offer(MODE_LOAD,      1'b0, 10'd512,  7'd124);
        offer(MODE_REGULAR,   1'b0, 10'd512,  7'd0);
        offer(MODE_REGULAR,   1'b1, 10'd512,  7'd0);
        offer(MODE_REGULAR,   1'b0, 10'd700,  7'd0);
        offer(MODE_LOAD,      1'b1, 10'd341,  7'd85);
        offer(MODE_REGULAR,   1'b1, 10'd341,  7'd42);
        offer(MODE_BYPASS,    1'b0, 10'd0,    7'd0);
        offer(MODE_BYPASS,    1'b1, 10'd1023, 7'd127);
        offer(MODE_TERMINATE, 1'b0, 10'd0,    7'd0);
        offer(MODE_TERMINATE, 1'b1, 10'd1023, 7'd127);
        offer(MODE_REGULAR,   1'b0, 10'd682,  7'd0);
        offer(MODE_BYPASS,    1'b1, 10'd0,    7'd0);
        offer(MODE_LOAD,      1'b0, 10'd1023, 7'd1);
        offer(MODE_REGULAR,   1'b0, 10'd1023, 7'd0);

        // Random: mostly context slices, some stray bins of any kind
        bins_sent = 0;
        while (bins_sent < RANDOM_BINS)
        begin
            idle_on = (bins_sent < CALM_FROM);
            if (bins_sent >= 100 && !pressure_done)
            begin
                hold_request  = 1'b1;
                pressure_done = 1'b1;
            end
            if ($urandom_range(0, 9) < 7)
                run_slice();
            else
                offer(mode_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      10'($urandom_range(0, 1023)), 7'($urandom_range(0, 127)));
        end
        idle_on  = 1'b0;
        s_tvalid <= 1'b0;

        // Drain, then allow for the longest terminate sequence
        settle = 0;
        repeat (2) @(posedge clk);
        while (groups_waiting > 0 && settle < 4000)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (40) @(posedge clk);
        if (fail_count == 0 && groups_waiting == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
